// ===== rtl/core/mips_pkg.sv =====
// ============================================================================
// MIPS executor package
// Opcodes, function codes, sizes and the control/status types shared by the
// controller and the datapath.
// ============================================================================
package mips_pkg;

    // reset value of the PC, the start address
    localparam logic [31:0] START_PC_RST = 32'h0040_0000;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE   = 6'd0;
    localparam logic [5:0] OP_BCOND   = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDI_U  = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTI_U  = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    // regimm codes
    localparam logic [4:0] RI_BLTZ   = 5'd0;
    localparam logic [4:0] RI_BGEZ   = 5'd1;
    localparam logic [4:0] RI_BLTZAL = 5'd16;
    localparam logic [4:0] RI_BGEZAL = 5'd17;

    // special function codes
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // pending load kinds
    localparam logic [2:0] LK_LB  = 3'd0;
    localparam logic [2:0] LK_LH  = 3'd1;
    localparam logic [2:0] LK_LW  = 3'd2;
    localparam logic [2:0] LK_LBU = 3'd3;
    localparam logic [2:0] LK_LHU = 3'd4;

    // special registers
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_V0   = 5'd2;
    localparam logic [4:0] REG_RA   = 5'd31;
    localparam logic [31:0] EXIT_CODE = 32'h0000_000A;

    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIVFIN,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic rd;
        logic exec;
        logic mul_fin;
        logic div_step;
        logic div_fin;
        logic push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic go_mul;
        logic go_div;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/mips32_instruction_executor.sv =====
// ============================================================================
// MIPS32 integer executor
// Runs one fetched instruction or one returned load word per input item.
// ============================================================================
// Input channel (i_in_valid / o_in_ready): i_action 0 carries the instruction
// fetched at the current PC, i_action 1 returns the word for a pending load.
// Output channel (o_out_valid / i_out_ready): one result per item with the
// next PC, any memory request, and halted / illegal flags.
// Config channel (i_cfg_valid / o_cfg_ready): writes the start PC and loads
// the PC at once; write only while the block is idle.
// Sequence: each item passes latch, register-file read, execute and result.
// MULT/MULTU go through a sign-correction state for the product after execute;
// DIV/DIVU go through the radix-2 divider (skipped for a zero divisor).
// One item is in flight.
// A new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the next result holds in the datapath
// until the output register frees.
// Reset (synchronous, active low): PC = 0x00400000, HI/LO and all general
// registers read zero, no load pending, not halted.
// ============================================================================
module mips32_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_load_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_start_pc,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_next_pc,
    output logic        o_mem_read,
    output logic        o_mem_wr,
    output logic [1:0]  o_mem_size,
    output logic [31:0] o_mem_addr,
    output logic [31:0] o_mem_wdata,
    output logic        o_halted,
    output logic        o_illegal
);
    import mips_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    mips_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mips_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_action),
        .i_instr_word   (i_instr_word),
        .i_load_word    (i_load_word),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_start_pc (i_cfg_start_pc),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_pc      (o_next_pc),
        .o_mem_read     (o_mem_read),
        .o_mem_wr       (o_mem_wr),
        .o_mem_size     (o_mem_size),
        .o_mem_addr     (o_mem_addr),
        .o_mem_wdata    (o_mem_wdata),
        .o_halted       (o_halted),
        .o_illegal      (o_illegal)
    );

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    // a result never requests both a load and a store
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_read && o_mem_wr))
        else $error("load and store requested together");

    // result only leaves through a push from the controller
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.push))
        else $error("result valid without push");

endmodule

// ===== rtl/core/mips_ctrl.sv =====
// ============================================================================
// MIPS executor controller
// Sequences read, execute, multiply/divide and result hand-off.
// ============================================================================
module mips_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mips_pkg::t_stat i_stat,
    output mips_pkg::t_cmd  o_cmd
);
    import mips_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.go_mul) begin
                    n_state = ST_MUL;
                end else if (i_stat.go_div) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL: begin
                o_cmd.mul_fin = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DIVFIN;
                end
            end
            ST_DIVFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mips_dp.sv =====
// ============================================================================
// MIPS executor datapath
// Register file, PC, HI/LO, decode and ALU, multiply, iterative divider
// and the result register.
// ============================================================================
module mips_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mips_pkg::t_cmd  i_cmd,
    output mips_pkg::t_stat o_stat,
    input  logic            i_action,
    input  logic [31:0]     i_instr_word,
    input  logic [31:0]     i_load_word,
    input  logic            i_cfg_valid,
    input  logic [31:0]     i_cfg_start_pc,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_next_pc,
    output logic            o_mem_read,
    output logic            o_mem_wr,
    output logic [1:0]      o_mem_size,
    output logic [31:0]     o_mem_addr,
    output logic [31:0]     o_mem_wdata,
    output logic            o_halted,
    output logic            o_illegal
);
    import mips_pkg::*;

    // latched item
    logic        r_act;
    logic [31:0] r_iw;
    logic [31:0] r_lw;

    // architectural state
    logic [31:0] r_pc;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic [4:0]  r_ld_dest;
    logic [2:0]  r_ld_kind;
    logic        r_ld_wait;
    logic        r_halted;

    // register file
    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_a_raw;
    logic [31:0] r_b_raw;
    logic        r_a_vld;
    logic        r_b_vld;
    logic [31:0] a;
    logic [31:0] b;

    // multiply / divide
    logic [63:0] r_prod;
    logic        r_msgn;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_qneg;
    logic        r_rneg;
    logic [33:0] div_trial;

    // pending result
    logic [31:0] r_res_npc;
    logic        r_res_mrd;
    logic        r_res_mwr;
    logic [1:0]  r_res_msz;
    logic [31:0] r_res_maddr;
    logic [31:0] r_res_mwd;
    logic        r_res_ill;
    logic        r_out_valid;

    // decode fields
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [4:0]  rb_addr;

    // execute results
    logic [31:0] n_npc;
    logic        n_mrd;
    logic        n_mwr;
    logic [1:0]  n_msz;
    logic [31:0] n_maddr;
    logic [31:0] n_mwd;
    logic        n_ill;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [31:0] wr_data;
    logic        set_hi;
    logic        set_lo;
    logic        set_halt;
    logic        set_load;
    logic        clr_load;
    logic [2:0]  n_ld_kind;
    logic        pc_wr;
    logic        go_mul;
    logic        go_div;

    logic [31:0] seq;
    logic [31:0] btgt;
    logic [31:0] jtgt;
    logic [31:0] addr_sum;
    logic [31:0] add_rr;
    logic [31:0] sub_rr;
    logic [31:0] add_ri;
    logic [31:0] ld_val;
    logic [4:0]  shamt_v;

    assign op      = r_iw[31:26];
    assign rs      = r_iw[25:21];
    assign rt      = r_iw[20:16];
    assign rd      = r_iw[15:11];
    assign sa      = r_iw[10:6];
    assign fn      = r_iw[5:0];
    assign imm     = {16'h0000, r_iw[15:0]};
    assign simm    = {{16{r_iw[15]}}, r_iw[15:0]};
    // syscall needs v0 on the second port
    assign rb_addr = (op == OP_RTYPE && fn == FN_SYSCALL) ? REG_V0 : rt;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act <= i_action;
            r_iw  <= i_instr_word;
            r_lw  <= i_load_word;
        end
    end

    // register file storage, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_a_raw <= r_rf[rs];
            r_b_raw <= r_rf[rb_addr];
        end
        if (wr_en) begin
            r_rf[wr_addr] <= wr_data;
        end
    end

    // entry valid bits; unwritten entries and entry zero read zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_a_vld <= r_rf_vld[rs];
                r_b_vld <= r_rf_vld[rb_addr];
            end
            if (wr_en) begin
                r_rf_vld[wr_addr] <= 1'b1;
            end
        end
    end

    assign a = r_a_vld ? r_a_raw : '0;
    assign b = r_b_vld ? r_b_raw : '0;

    // shared adders
    assign seq      = r_pc + 32'd4;
    assign btgt     = r_pc + {simm[29:0], 2'b00};
    assign jtgt     = {r_pc[31:28], r_iw[25:0], 2'b00};
    assign addr_sum = a + simm;
    assign add_ri   = addr_sum;
    assign add_rr   = a + b;
    assign sub_rr   = a - b;
    assign shamt_v  = a[4:0];

    // load data formatting
    always_comb begin
        case (r_ld_kind)
            LK_LB:   ld_val = {{24{r_lw[7]}}, r_lw[7:0]};
            LK_LH:   ld_val = {{16{r_lw[15]}}, r_lw[15:0]};
            LK_LBU:  ld_val = {24'h000000, r_lw[7:0]};
            LK_LHU:  ld_val = {16'h0000, r_lw[15:0]};
            default: ld_val = r_lw;
        endcase
    end

    // execute decode
    always_comb begin
        n_npc     = r_pc;
        n_mrd     = 1'b0;
        n_mwr     = 1'b0;
        n_msz     = SZ_BYTE;
        n_maddr   = '0;
        n_mwd     = '0;
        n_ill     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = rd;
        wr_data   = '0;
        set_hi    = 1'b0;
        set_lo    = 1'b0;
        set_halt  = 1'b0;
        set_load  = 1'b0;
        clr_load  = 1'b0;
        n_ld_kind = LK_LW;
        pc_wr     = 1'b0;
        go_mul    = 1'b0;
        go_div    = 1'b0;
        if (r_halted) begin
            // everything ignored
        end else if (r_act) begin
            if (r_ld_wait) begin
                wr_en    = 1'b1;
                wr_addr  = r_ld_dest;
                wr_data  = ld_val;
                clr_load = 1'b1;
            end
        end else if (!r_ld_wait) begin
            pc_wr = 1'b1;
            n_npc = seq;
            unique case (op)
                OP_J: begin
                    n_npc = jtgt;
                end
                OP_JAL: begin
                    n_npc   = jtgt;
                    wr_en   = 1'b1;
                    wr_addr = REG_RA;
                    wr_data = seq;
                end
                OP_BEQ: begin
                    if (a == b) n_npc = btgt;
                end
                OP_BNE: begin
                    if (a != b) n_npc = btgt;
                end
                OP_BLEZ: begin
                    if (a[31] || a == '0) n_npc = btgt;
                end
                OP_BGTZ: begin
                    if (!a[31] && a != '0) n_npc = btgt;
                end
                OP_ADDI: begin
                    wr_addr = rt;
                    wr_data = add_ri;
                    wr_en   = !((a[31] == simm[31]) && (add_ri[31] != a[31]));
                end
                OP_ADDI_U: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = add_ri;
                end
                OP_SLTI: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = {31'd0, $signed(a) < $signed(simm)};
                end
                OP_SLTI_U: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = {31'd0, a < simm};
                end
                OP_ANDI: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = a & imm;
                end
                OP_ORI: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = a | imm;
                end
                OP_XORI: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = a ^ imm;
                end
                OP_LUI: begin
                    wr_en   = 1'b1;
                    wr_addr = rt;
                    wr_data = {r_iw[15:0], 16'h0000};
                end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
                    n_mrd    = 1'b1;
                    n_maddr  = addr_sum;
                    set_load = 1'b1;
                    case (op)
                        OP_LB:   begin n_ld_kind = LK_LB;  n_msz = SZ_BYTE; end
                        OP_LH:   begin n_ld_kind = LK_LH;  n_msz = SZ_HALF; end
                        OP_LBU:  begin n_ld_kind = LK_LBU; n_msz = SZ_BYTE; end
                        OP_LHU:  begin n_ld_kind = LK_LHU; n_msz = SZ_HALF; end
                        default: begin n_ld_kind = LK_LW;  n_msz = SZ_WORD; end
                    endcase
                end
                OP_SB: begin
                    n_mwr   = 1'b1;
                    n_maddr = addr_sum;
                    n_msz   = SZ_BYTE;
                    n_mwd   = {24'h000000, b[7:0]};
                end
                OP_SH: begin
                    n_mwr   = 1'b1;
                    n_maddr = addr_sum;
                    n_msz   = SZ_HALF;
                    n_mwd   = {16'h0000, b[15:0]};
                end
                OP_SW: begin
                    n_mwr   = 1'b1;
                    n_maddr = addr_sum;
                    n_msz   = SZ_WORD;
                    n_mwd   = b;
                end
                OP_BCOND: begin
                    unique case (rt)
                        RI_BLTZ: begin
                            if (a[31]) n_npc = btgt;
                        end
                        RI_BGEZ: begin
                            if (!a[31]) n_npc = btgt;
                        end
                        RI_BLTZAL: begin
                            if (a[31]) n_npc = btgt;
                            wr_en   = 1'b1;
                            wr_addr = REG_RA;
                            wr_data = seq;
                        end
                        RI_BGEZAL: begin
                            if (!a[31]) n_npc = btgt;
                            wr_en   = 1'b1;
                            wr_addr = REG_RA;
                            wr_data = seq;
                        end
                        default: begin
                            n_npc = r_pc;
                            n_ill = 1'b1;
                        end
                    endcase
                end
                OP_RTYPE: begin
                    unique case (fn)
                        FN_SLL:  begin wr_en = 1'b1; wr_data = b << sa; end
                        FN_SRL:  begin wr_en = 1'b1; wr_data = b >> sa; end
                        FN_SRA:  begin wr_en = 1'b1; wr_data = $unsigned($signed(b) >>> sa); end
                        FN_SLLV: begin wr_en = 1'b1; wr_data = b << shamt_v; end
                        FN_SRLV: begin wr_en = 1'b1; wr_data = b >> shamt_v; end
                        FN_SRAV: begin
                            wr_en   = 1'b1;
                            wr_data = $unsigned($signed(b) >>> shamt_v);
                        end
                        FN_JR:   begin n_npc = a; end
                        FN_JALR: begin n_npc = a; wr_en = 1'b1; wr_data = seq; end
                        FN_SYSCALL: begin
                            set_halt = (b == EXIT_CODE);
                        end
                        FN_MFHI: begin wr_en = 1'b1; wr_data = r_hi; end
                        FN_MTHI: begin set_hi = 1'b1; end
                        FN_MFLO: begin wr_en = 1'b1; wr_data = r_lo; end
                        FN_MTLO: begin set_lo = 1'b1; end
                        FN_MULT, FN_MULTU: begin go_mul = 1'b1; end
                        FN_DIV, FN_DIVU: begin go_div = (b != '0); end
                        FN_ADD: begin
                            wr_data = add_rr;
                            wr_en   = !((a[31] == b[31]) && (add_rr[31] != a[31]));
                        end
                        FN_ADDU: begin wr_en = 1'b1; wr_data = add_rr; end
                        FN_SUB: begin
                            wr_data = sub_rr;
                            wr_en   = !((a[31] != b[31]) && (sub_rr[31] != a[31]));
                        end
                        FN_SUBU: begin wr_en = 1'b1; wr_data = sub_rr; end
                        FN_AND:  begin wr_en = 1'b1; wr_data = a & b; end
                        FN_OR:   begin wr_en = 1'b1; wr_data = a | b; end
                        FN_XOR:  begin wr_en = 1'b1; wr_data = a ^ b; end
                        FN_NOR:  begin wr_en = 1'b1; wr_data = ~(a | b); end
                        FN_SLT:  begin
                            wr_en   = 1'b1;
                            wr_data = {31'd0, $signed(a) < $signed(b)};
                        end
                        FN_SLTU: begin wr_en = 1'b1; wr_data = {31'd0, a < b}; end
                        default: begin end
                    endcase
                end
                default: begin
                    n_npc = r_pc;
                    n_ill = 1'b1;
                end
            endcase
        end
        // only commit in the execute cycle; register zero never written
        wr_en = wr_en && i_cmd.exec && (wr_addr != REG_ZERO);
    end

    assign o_stat.go_mul   = go_mul;
    assign o_stat.go_div   = go_div;
    assign o_stat.div_last = (r_cnt == DIV_LAST);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // divider step: one quotient bit per cycle
    assign div_trial = {1'b0, r_rem, r_quo[31]} - {2'b00, r_dvs};

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= START_PC_RST;
            r_hi      <= '0;
            r_lo      <= '0;
            r_ld_dest <= '0;
            r_ld_kind <= '0;
            r_ld_wait <= 1'b0;
            r_halted  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pc <= i_cfg_start_pc;
            end
            if (i_cmd.exec) begin
                if (pc_wr) r_pc <= n_npc;
                if (set_hi) r_hi <= a;
                if (set_lo) r_lo <= a;
                if (set_halt) r_halted <= 1'b1;
                if (set_load) begin
                    r_ld_wait <= 1'b1;
                    r_ld_dest <= rt;
                    r_ld_kind <= n_ld_kind;
                end
                if (clr_load) r_ld_wait <= 1'b0;
            end
            // signed correction of the unsigned product
            if (i_cmd.mul_fin) begin
                r_lo <= r_prod[31:0];
                r_hi <= r_prod[63:32] - ((r_msgn && r_a_raw[31] && r_a_vld) ? b : 32'd0)
                                      - ((r_msgn && r_b_raw[31] && r_b_vld) ? a : 32'd0);
            end
            if (i_cmd.div_fin) begin
                r_lo <= r_qneg ? (32'd0 - r_quo) : r_quo;
                r_hi <= r_rneg ? (32'd0 - r_rem) : r_rem;
            end
        end
    end

    // multiplier and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_prod <= a * b;
            r_msgn <= (fn == FN_MULT);
            r_rem  <= '0;
            r_cnt  <= '0;
            r_quo  <= (fn == FN_DIV && a[31]) ? (32'd0 - a) : a;
            r_dvs  <= (fn == FN_DIV && b[31]) ? (32'd0 - b) : b;
            r_qneg <= (fn == FN_DIV) && (a[31] ^ b[31]);
            r_rneg <= (fn == FN_DIV) && a[31];
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            if (!div_trial[33]) begin
                r_rem <= div_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // pending result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_npc   <= n_npc;
            r_res_mrd   <= n_mrd;
            r_res_mwr   <= n_mwr;
            r_res_msz   <= n_msz;
            r_res_maddr <= n_maddr;
            r_res_mwd   <= n_mwd;
            r_res_ill   <= n_ill;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_next_pc   <= r_res_npc;
            o_mem_read  <= r_res_mrd;
            o_mem_wr    <= r_res_mwr;
            o_mem_size  <= r_res_msz;
            o_mem_addr  <= r_res_maddr;
            o_mem_wdata <= r_res_mwd;
            o_halted    <= r_halted;
            o_illegal   <= r_res_ill;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
